// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CXYHS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define CXYHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/cxyhs_pkg.sv =====
package cxyhs_pkg;

  localparam int CHROMA_W = 16;
  localparam int CODE_W   = 8;
  localparam int HUE_W    = 9;
  localparam int THRESH_W = 17;

  localparam logic [CODE_W-1:0] CODE_MIN = 8'd0;
  localparam logic [CODE_W-1:0] CODE_MAX = 8'd255;
  // Highest code that the threshold search may return
  localparam logic [CODE_W-1:0] CODE_TOP = 8'd254;

  localparam logic [HUE_W-1:0] HUE_BASE_RED   = 9'd0;
  localparam logic [HUE_W-1:0] HUE_BASE_GREEN = 9'd120;
  localparam logic [HUE_W-1:0] HUE_BASE_BLUE  = 9'd240;
  localparam logic [10:0]      HUE_WRAP       = 11'd360;
  localparam logic [15:0]      HUE_SECTOR     = 16'd60;
  localparam logic [15:0]      SAT_SCALE      = 16'd255;

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } hue_sel_e;

  // Clamp flags that ride along with one channel through the divider
  typedef struct packed {
    logic yz;   // y is zero, channel takes its fixed code
    logic le0;  // numerator at or below zero
    logic ge1;  // numerator at or above the divisor
  } chan_flags_t;

  typedef struct packed {
    logic     neg;
    hue_sel_e sel;
  } hue_side_t;

  typedef logic [THRESH_W-1:0] thresh_t;
  typedef thresh_t thresh_tbl_t [256];

  // Fixed-point matrix coefficient magnitude from a micro-unit constant
  function automatic longint coef_q(input longint micro, input int frac);
    return (micro * (longint'(1) << frac) + 64'sd500000) / 64'sd1000000;
  endfunction

  // Smallest 16-bit fraction at or above the linear threshold of each code.
  // Upper codes: t^5 * 269025^12 >= (1000k + 14025)^12 * 2^80.
  function automatic thresh_tbl_t build_thresh();
    thresh_tbl_t   tbl;
    logic [319:0]  base12;
    logic [319:0]  rhs;
    logic [319:0]  lhs;
    longint        lo;
    longint        hi;
    longint        mid;
    base12 = 320'd1;
    for (int i = 0; i < 12; i++) begin
      base12 = base12 * 320'd269025;
    end
    tbl[0]   = '0;
    tbl[255] = 17'd65536;
    for (int k = 1; k <= 254; k++) begin
      if (k <= 10) begin
        tbl[k] = THRESH_W'((longint'(k) * 6553600 + 329459) / 329460);
      end else begin
        rhs = 320'd1;
        for (int i = 0; i < 12; i++) begin
          rhs = rhs * 320'(1000 * k + 14025);
        end
        rhs = rhs << 80;
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
          mid = (lo + hi) >> 1;
          lhs = base12;
          for (int i = 0; i < 5; i++) begin
            lhs = lhs * 320'(mid);
          end
          if (lhs >= rhs) begin
            hi = mid;
          end else begin
            lo = mid + 1;
          end
        end
        tbl[k] = THRESH_W'(lo);
      end
    end
    return tbl;
  endfunction

  localparam thresh_tbl_t THRESH = build_thresh();

endpackage

// ===== rtl/cxyhs_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// The dividend must be below divisor * 2^QW.
module cxyhs_div #(
  parameter int DW = 8,
  parameter int QW = 8,
  parameter int SW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [DW+QW-1:0]     dividend_i,
  input  logic [DW-1:0]        divisor_i,
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic [QW-1:0]        quot_o,
  output logic [SW-1:0]        side_o
);

  localparam int NW = DW + QW;

  logic [NW-1:0] rem_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [SW-1:0] side_q [QW];
  logic [QW-1:0] vld_q;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic [NW-1:0] shifted;
    logic          take;
    logic [NW-1:0] rem_d;
    logic [QW-1:0] quo_d;

    if (s == 0) begin : g_first
      assign rem_in  = dividend_i;
      assign den_in  = divisor_i;
      assign quo_in  = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    assign shifted = NW'(den_in) << (QW - 1 - s);
    assign take    = rem_in >= shifted;
    assign rem_d   = take ? rem_in - shifted : rem_in;
    assign quo_d   = {quo_in[QW-2:0], take};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        den_q[s]  <= den_in;
        quo_q[s]  <= quo_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// ===== rtl/cxyhs_chan.sv =====
// One sRGB channel: matrix row, divide by y, inverse gamma by threshold search.
module cxyhs_chan
  import cxyhs_pkg::*;
#(
  parameter int                LINEAR_FRAC_BITS = 16,
  parameter int                COEF_FRAC_BITS   = 16,
  parameter longint            COEF_X           = 0,
  parameter longint            COEF_Y           = 0,
  parameter longint            COEF_K           = 0,
  parameter logic [CODE_W-1:0] YZ_CODE          = CODE_MIN
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [CHROMA_W-1:0] x_i,
  input  logic [CHROMA_W-1:0] y_i,
  output logic                valid_o,
  output logic [CODE_W-1:0]   code_o
);

  localparam int L  = LINEAR_FRAC_BITS;
  localparam int C  = COEF_FRAC_BITS;
  localparam int CW = C + 4;
  localparam int PW = CW + CHROMA_W + 1;
  localparam int NW = C + 21;
  localparam int DW = CHROMA_W + C;
  localparam int FW = $bits(chan_flags_t);
  localparam int SRCH = 8;

  localparam logic signed [CW-1:0] KX = CW'(COEF_X);
  localparam logic signed [CW-1:0] KY = CW'(COEF_Y);
  localparam logic signed [NW-1:0] KK = NW'(COEF_K);

  // Stage 1: products
  logic signed [PW-1:0] prx_d, pry_d, prx_q, pry_q;
  logic [CHROMA_W-1:0]  y1_q;
  logic                 v1_q;

  assign prx_d = PW'(KX) * PW'($signed({1'b0, x_i}));
  assign pry_d = PW'(KY) * PW'($signed({1'b0, y_i}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prx_q <= prx_d;
      pry_q <= pry_d;
      y1_q  <= y_i;
    end
  end

  // Stage 2: numerator
  logic signed [NW-1:0] n_d, n_q;
  logic [CHROMA_W-1:0]  y2_q;
  logic                 v2_q;

  assign n_d = NW'(prx_q) + NW'(pry_q) + KK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q  <= n_d;
      y2_q <= y1_q;
    end
  end

  // Stage 3: clamp decisions and divider operands
  logic [DW-1:0]   den_w;
  chan_flags_t     flags_d, flags_q;
  logic [DW+L-1:0] num_d, num_q;
  logic [DW-1:0]   den_q;
  logic            v3_q;

  always_comb begin
    den_w       = {y2_q, {C{1'b0}}};
    flags_d.yz  = (y2_q == '0);
    flags_d.le0 = n_q[NW-1] || (n_q == '0);
    flags_d.ge1 = !n_q[NW-1] && ($unsigned(n_q) >= NW'(den_w));
    if (flags_d.le0 || flags_d.ge1) begin
      num_d = '0;
    end else begin
      num_d = {n_q[DW-1:0], {L{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q   <= num_d;
      den_q   <= den_w;
      flags_q <= flags_d;
    end
  end

  // Linear value as an L-bit fraction
  logic          dv_v;
  logic [L-1:0]  dv_lq;
  logic [FW-1:0] dv_side;

  cxyhs_div #(
    .DW (DW),
    .QW (L),
    .SW (FW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en_i),
    .valid_i    (v3_q),
    .dividend_i (num_q),
    .divisor_i  (den_q),
    .side_i     (flags_q),
    .valid_o    (dv_v),
    .quot_o     (dv_lq),
    .side_o     (dv_side)
  );

  // Binary search over the monotone threshold table, one code bit a stage
  logic [L-1:0]      s_lq_q  [SRCH];
  logic [CODE_W-1:0] s_code_q[SRCH];
  chan_flags_t       s_fl_q  [SRCH];
  logic [SRCH-1:0]   s_vld_q;

  for (genvar j = 0; j < SRCH; j++) begin : g_srch
    logic [L-1:0]      lq_in;
    logic [CODE_W-1:0] code_in;
    chan_flags_t       fl_in;
    logic              vld_in;
    logic [CODE_W-1:0] cand;
    logic              hit;
    logic [CODE_W-1:0] code_d;

    if (j == 0) begin : g_first
      assign lq_in   = dv_lq;
      assign code_in = CODE_MIN;
      assign fl_in   = chan_flags_t'(dv_side);
      assign vld_in  = dv_v;
    end else begin : g_next
      assign lq_in   = s_lq_q[j-1];
      assign code_in = s_code_q[j-1];
      assign fl_in   = s_fl_q[j-1];
      assign vld_in  = s_vld_q[j-1];
    end

    assign cand   = code_in | (CODE_W'(1) << (SRCH - 1 - j));
    assign hit    = (cand <= CODE_TOP) &&
                    ({1'b0, lq_in, 16'h0000} >= {THRESH[cand], {L{1'b0}}});
    assign code_d = hit ? cand : code_in;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_vld_q[j] <= 1'b0;
      end else if (en_i) begin
        s_vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_lq_q[j]   <= lq_in;
        s_code_q[j] <= code_d;
        s_fl_q[j]   <= fl_in;
      end
    end
  end

  // Final code with clamps
  chan_flags_t       fin_fl;
  logic [CODE_W-1:0] code_d, code_q;
  logic              vo_q;

  always_comb begin
    fin_fl = s_fl_q[SRCH-1];
    priority if (fin_fl.yz) begin
      code_d = YZ_CODE;
    end else if (fin_fl.le0) begin
      code_d = CODE_MIN;
    end else if (fin_fl.ge1) begin
      code_d = CODE_MAX;
    end else begin
      code_d = s_code_q[SRCH-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= s_vld_q[SRCH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      code_q <= code_d;
    end
  end

  assign valid_o = vo_q;
  assign code_o  = code_q;

endmodule

// ===== rtl/cxyhs_hsv.sv =====
// RGB codes to hue and saturation, ending in the output register.
module cxyhs_hsv
  import cxyhs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [CODE_W-1:0] r_i,
  input  logic [CODE_W-1:0] g_i,
  input  logic [CODE_W-1:0] b_i,
  output logic              valid_o,
  output logic [HUE_W-1:0]  hue_o,
  output logic [CODE_W-1:0] sat_o
);

  // Stage A: max, min, sector, signed difference
  logic [CODE_W-1:0] mx_d, mn_d, mx_q, mn_q;
  hue_sel_e          sel_d, sel_q;
  logic signed [8:0] diff_d, diff_q;
  logic              va_q;

  always_comb begin
    mx_d = (r_i > g_i) ? r_i : g_i;
    if (b_i > mx_d) begin
      mx_d = b_i;
    end
    mn_d = (r_i < g_i) ? r_i : g_i;
    if (b_i < mn_d) begin
      mn_d = b_i;
    end
    // red wins ties, then green
    priority if (mx_d == r_i) begin
      sel_d  = SEL_RED;
      diff_d = $signed({1'b0, g_i}) - $signed({1'b0, b_i});
    end else if (mx_d == g_i) begin
      sel_d  = SEL_GREEN;
      diff_d = $signed({1'b0, b_i}) - $signed({1'b0, r_i});
    end else begin
      sel_d  = SEL_BLUE;
      diff_d = $signed({1'b0, r_i}) - $signed({1'b0, g_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q   <= mx_d;
      mn_q   <= mn_d;
      sel_q  <= sel_d;
      diff_q <= diff_d;
    end
  end

  // Stage B: divider operands
  logic [CODE_W-1:0] delta_w;
  logic [8:0]        absd_w;
  logic [15:0]       hnum_d, snum_d, hnum_q, snum_q;
  logic [CODE_W-1:0] delta_q, mxb_q;
  hue_side_t         hside_d, hside_q;
  logic              zero_d, zero_q;
  logic              vb_q;

  always_comb begin
    delta_w     = mx_q - mn_q;
    zero_d      = (delta_w == '0);
    hside_d.neg = diff_q[8];
    hside_d.sel = sel_q;
    absd_w      = diff_q[8] ? 9'(-diff_q) : 9'(diff_q);
    hnum_d      = 16'(absd_w[7:0]) * HUE_SECTOR;
    snum_d      = 16'(delta_w) * SAT_SCALE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hnum_q  <= hnum_d;
      snum_q  <= snum_d;
      delta_q <= delta_w;
      mxb_q   <= mx_q;
      hside_q <= hside_d;
      zero_q  <= zero_d;
    end
  end

  // Two dividers in lockstep
  logic                    hd_v;
  logic [CODE_W-1:0]       hq, sq;
  logic [$bits(hue_side_t)-1:0] hd_side;
  logic                    sd_zero;

  cxyhs_div #(
    .DW (CODE_W),
    .QW (CODE_W),
    .SW ($bits(hue_side_t))
  ) u_hue_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en_i),
    .valid_i    (vb_q),
    .dividend_i (hnum_q),
    .divisor_i  (delta_q),
    .side_i     (hside_q),
    .valid_o    (hd_v),
    .quot_o     (hq),
    .side_o     (hd_side)
  );

  cxyhs_div #(
    .DW (CODE_W),
    .QW (CODE_W),
    .SW (1)
  ) u_sat_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en_i),
    .valid_i    (vb_q),
    .dividend_i (snum_q),
    .divisor_i  (mxb_q),
    .side_i     (zero_q),
    .valid_o    (),
    .quot_o     (sq),
    .side_o     (sd_zero)
  );

  // Stage C: signed hue, wrap, output register
  hue_side_t          hs;
  logic [HUE_W-1:0]   base;
  logic signed [10:0] hsum;
  logic [HUE_W-1:0]   hue_d, hue_q;
  logic [CODE_W-1:0]  sat_d, sat_q;
  logic               vo_q;

  always_comb begin
    hs = hue_side_t'(hd_side);
    unique case (hs.sel)
      SEL_RED:   base = HUE_BASE_RED;
      SEL_GREEN: base = HUE_BASE_GREEN;
      SEL_BLUE:  base = HUE_BASE_BLUE;
      default:   base = HUE_BASE_RED;
    endcase
    if (hs.neg) begin
      hsum = $signed({2'b00, base}) - $signed({3'b000, hq});
    end else begin
      hsum = $signed({2'b00, base}) + $signed({3'b000, hq});
    end
    if (hsum < 0) begin
      hsum = hsum + $signed(HUE_WRAP);
    end
    if (sd_zero) begin
      hue_d = '0;
      sat_d = '0;
    end else begin
      hue_d = hsum[HUE_W-1:0];
      sat_d = sq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= hd_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
    end
  end

  assign valid_o = vo_q;
  assign hue_o   = hue_q;
  assign sat_o   = sat_q;

endmodule

// ===== rtl/cie_xy_to_hue_saturation.sv =====
// CIE xy chromaticity to HSV hue and saturation.
// Input stream: one word per chromaticity pair, x in tdata[15:0] and y in
// tdata[31:16], both unsigned fractions of 65536. Luminance is taken as one.
// Output stream: one word per input, hue 0..359 in tdata[8:0] and saturation
// 0..255 in tdata[16:9]. Results leave in input order.
// Throughput: one word per cycle while the output is not stalled.
// The pipeline depth is set by the per-channel divider (one bit of the linear
// value per stage), the 8-stage gamma threshold search and the 8-stage hue
// and saturation dividers.
// A stalled receiver freezes the whole pipeline; a one-word skid register at
// the input still takes the word offered in that cycle, and s_axis_tready
// drops while it is full. Nothing is lost or repeated across a stall.
// Reset clears every valid bit and the skid valid flag; the block accepts a
// word in the first cycle after reset is released.
module cie_xy_to_hue_saturation
  import cxyhs_pkg::*;
#(
  parameter int LINEAR_FRAC_BITS = 16,
  parameter int COEF_FRAC_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] x_chroma, [31:16] y_chroma
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [8:0] hue, [16:9] saturation, rest zero
);

  localparam int C = COEF_FRAC_BITS;

  localparam longint R_A = coef_q(3240479, C);
  localparam longint R_B = -coef_q(1537150, C);
  localparam longint R_C = -coef_q(498535, C);
  localparam longint G_A = -coef_q(969256, C);
  localparam longint G_B = coef_q(1875992, C);
  localparam longint G_C = coef_q(41556, C);
  localparam longint B_A = coef_q(55648, C);
  localparam longint B_B = -coef_q(204043, C);
  localparam longint B_C = coef_q(1057311, C);

  // Fold z = 1 - x - y into the x and y terms plus a constant
  localparam longint ONE = longint'(1) << CHROMA_W;

  logic en;
  logic skid_v_q;
  logic skid_v_d;
  logic [31:0] skid_q;
  logic acc;
  logic pipe_v;
  logic [31:0] pipe_w;

  logic              r_v;
  logic [CODE_W-1:0] r_code, g_code, b_code;
  logic              out_v;
  logic [HUE_W-1:0]  hue;
  logic [CODE_W-1:0] sat;

  // Whole pipeline advances unless the output word is stuck
  assign en            = !out_v || m_axis_tready;
  assign s_axis_tready = !skid_v_q;
  assign acc           = s_axis_tvalid && !skid_v_q;
  assign pipe_v        = skid_v_q || acc;
  assign pipe_w        = skid_v_q ? skid_q : s_axis_tdata;

  always_comb begin
    skid_v_d = skid_v_q;
    if (en) begin
      skid_v_d = 1'b0;
    end else if (acc) begin
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
    end
  end

  // Hold the offered word while the pipeline is frozen
  always_ff @(posedge clk_i) begin
    if (!en && acc) begin
      skid_q <= s_axis_tdata;
    end
  end

  cxyhs_chan #(
    .LINEAR_FRAC_BITS (LINEAR_FRAC_BITS),
    .COEF_FRAC_BITS   (COEF_FRAC_BITS),
    .COEF_X           (R_A - R_C),
    .COEF_Y           (R_B - R_C),
    .COEF_K           (R_C * ONE),
    .YZ_CODE          (CODE_MIN)
  ) u_chan_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pipe_v),
    .x_i     (pipe_w[15:0]),
    .y_i     (pipe_w[31:16]),
    .valid_o (r_v),
    .code_o  (r_code)
  );

  cxyhs_chan #(
    .LINEAR_FRAC_BITS (LINEAR_FRAC_BITS),
    .COEF_FRAC_BITS   (COEF_FRAC_BITS),
    .COEF_X           (G_A - G_C),
    .COEF_Y           (G_B - G_C),
    .COEF_K           (G_C * ONE),
    .YZ_CODE          (CODE_MAX)
  ) u_chan_g (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pipe_v),
    .x_i     (pipe_w[15:0]),
    .y_i     (pipe_w[31:16]),
    .valid_o (),
    .code_o  (g_code)
  );

  cxyhs_chan #(
    .LINEAR_FRAC_BITS (LINEAR_FRAC_BITS),
    .COEF_FRAC_BITS   (COEF_FRAC_BITS),
    .COEF_X           (B_A - B_C),
    .COEF_Y           (B_B - B_C),
    .COEF_K           (B_C * ONE),
    .YZ_CODE          (CODE_MIN)
  ) u_chan_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pipe_v),
    .x_i     (pipe_w[15:0]),
    .y_i     (pipe_w[31:16]),
    .valid_o (),
    .code_o  (b_code)
  );

  cxyhs_hsv u_hsv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r_v),
    .r_i     (r_code),
    .g_i     (g_code),
    .b_i     (b_code),
    .valid_o (out_v),
    .hue_o   (hue),
    .sat_o   (sat)
  );

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {7'b0, sat, hue};

endmodule

// ===== rtl/cxyhs_chk.sv =====
`include "assert_macros.svh"

module cxyhs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // Hue stays inside one turn
  `CXYHS_ASSERT_NOW(a_hue_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[8:0] < 9'd360)

  // Zero saturation means a gray word, whose hue is zero
  `CXYHS_ASSERT_NOW(a_gray_hue, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[16:9] == 8'd0),
                    m_axis_tdata[8:0] == 9'd0)

  // Input backpressure only follows an output stall
  `CXYHS_ASSERT_NOW(a_ready_cause, clk_i, rst_ni, !s_axis_tready,
                    $past(m_axis_tvalid && !m_axis_tready))

  // A stalled word holds
  `CXYHS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata))

  // An offered input word holds until taken
  `CXYHS_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, s_axis_tvalid && !s_axis_tready,
                     s_axis_tvalid && $stable(s_axis_tdata))

endmodule

bind cie_xy_to_hue_saturation cxyhs_chk u_cxyhs_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
